// ----- src/cmxp_pkg.sv -----
// Shared types, constants and bit widening for the cursor mask/XOR plot unit.
`timescale 1ns / 1ps

package cmxp_pkg;

	localparam int ROW_W   = 16;
	localparam int WORD_W  = 64;
	localparam int DEPTH_W = 2;
	localparam int SHIFT_W = 4;
	localparam int TRIM_W  = 2;
	localparam int CFG_W   = 4;   // widest register (pixel_shift)
	localparam int IDX_W   = 2;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_DEPTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_SHIFT = 2'd1;
	localparam logic [IDX_W-1:0] REG_TRIM  = 2'd2;

	// log2 of bits per pixel
	localparam logic [1:0] LG_1BPP = 2'd0;
	localparam logic [1:0] LG_2BPP = 2'd1;
	localparam logic [1:0] LG_4BPP = 2'd2;

	typedef struct packed {
		logic [DEPTH_W-1:0]       depth_mode;
		logic [SHIFT_W-1:0]       pixel_shift;
		logic signed [TRIM_W-1:0] trim_side;
	} cfg_t;

	typedef struct packed {
		logic [ROW_W-1:0]  face_row;
		logic [ROW_W-1:0]  mask_row;
		logic [WORD_W-1:0] dest_a;
		logic [WORD_W-1:0] dest_b;
		logic              last_row;
	} row_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_a;
		logic [WORD_W-1:0] out_b;
		logic              a_written;
		logic              b_written;
		logic              last_out;
	} res_item_t;

	// Replicate each row bit into a 1, 2 or 4 bit pixel; leftmost pixel stays on top
	function automatic logic [WORD_W-1:0] widen(input logic [ROW_W-1:0] row,
			input logic [1:0] lg);
		logic [WORD_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < ROW_W; i++) begin
			case (lg)
				LG_1BPP: acc[i]       = row[i];
				LG_2BPP: acc[2*i +: 2] = {2{row[i]}};
				default: acc[4*i +: 4] = {4{row[i]}};
			endcase
		end
		return acc;
	endfunction

endpackage

// ----- src/cmxp_ifs.sv -----
// Valid/ready channel interfaces for cursor rows and merged results.
`timescale 1ns / 1ps

interface cmxp_row_if;
	logic                      valid;
	logic                      ready;
	logic [cmxp_pkg::ROW_W-1:0]  face_row;
	logic [cmxp_pkg::ROW_W-1:0]  mask_row;
	logic [cmxp_pkg::WORD_W-1:0] dest_a;
	logic [cmxp_pkg::WORD_W-1:0] dest_b;
	logic                      last_row;

	modport source (output valid, face_row, mask_row, dest_a, dest_b, last_row,
		input ready);
	modport sink (input valid, face_row, mask_row, dest_a, dest_b, last_row,
		output ready);
endinterface

interface cmxp_res_if;
	logic                      valid;
	logic                      ready;
	logic [cmxp_pkg::WORD_W-1:0] out_a;
	logic [cmxp_pkg::WORD_W-1:0] out_b;
	logic                      a_written;
	logic                      b_written;
	logic                      last_out;

	modport source (output valid, out_a, out_b, a_written, b_written, last_out,
		input ready);
	modport sink (input valid, out_a, out_b, a_written, b_written, last_out,
		output ready);
endinterface

// ----- src/cmxp_merge.sv -----
// Widen, shift and mask/XOR merge of one cursor row into destination words.
`timescale 1ns / 1ps

module cmxp_merge (
	input  cmxp_pkg::cfg_t      cfg,
	input  cmxp_pkg::row_item_t item,
	output cmxp_pkg::res_item_t res
);
	import cmxp_pkg::*;

	logic [1:0]        lg;
	logic [6:0]        w;
	logic [5:0]        s;
	logic [6:0]        ls;
	logic [WORD_W-1:0] wmask;
	logic [WORD_W-1:0] face;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] da;
	logic [WORD_W-1:0] db;
	logic [WORD_W-1:0] mr;
	logic [WORD_W-1:0] fr;
	logic [WORD_W-1:0] ml;
	logic [WORD_W-1:0] fl;
	logic              right;
	logic              left;

	// Depth code three behaves as 4bpp
	assign lg = (cfg.depth_mode >= LG_4BPP) ? LG_4BPP : cfg.depth_mode;

	always_comb begin
		case (lg)
			LG_1BPP: wmask = {{(WORD_W-16){1'b0}}, {16{1'b1}}};
			LG_2BPP: wmask = {{(WORD_W-32){1'b0}}, {32{1'b1}}};
			default: wmask = {WORD_W{1'b1}};
		endcase
	end

	// Row width and bit offsets
	assign w  = 7'd16 << lg;
	assign s  = {2'b00, cfg.pixel_shift} << lg;
	assign ls = w - {1'b0, s};

	assign face = widen(item.face_row, lg);
	assign mask = widen(item.mask_row, lg);
	assign da   = item.dest_a & wmask;
	assign db   = item.dest_b & wmask;

	// Right part shifts down, the spill moves to the top of the row
	assign mr = mask >> s;
	assign fr = face >> s;
	assign ml = (mask << ls) & wmask;
	assign fl = (face << ls) & wmask;

	// Non-negative trim keeps the right part; zero or negative keeps the left part if the offset is nonzero
	assign right = ~cfg.trim_side[TRIM_W-1];
	assign left  = (s != '0) && (cfg.trim_side[TRIM_W-1] || (cfg.trim_side == '0));

	always_comb begin
		res.out_a     = da;
		res.out_b     = db;
		res.a_written = 1'b0;
		res.b_written = 1'b0;
		res.last_out  = item.last_row;
		if (right) begin
			res.out_a     = ((da & ~mr) ^ fr) & wmask;
			res.a_written = 1'b1;
			if (left) begin
				res.out_b     = (db & ~ml) ^ fl;
				res.b_written = 1'b1;
			end
		end else if (left) begin
			res.out_a     = (da & ~ml) ^ fl;
			res.a_written = 1'b1;
		end
	end

endmodule

// ----- src/cursor_mask_xor_plot_unit.sv -----
// Top level of the cursor mask/XOR plot unit: config registers and two-stage pipeline.
//
// Usage: each transaction on the cursor channel carries one 16-pixel cursor row
// (face and mask bits) plus the destination words it lands on. The merged words
// leave on the merged channel, one result per row, in order, with flags telling
// which destination words were modified and a copy of the last-row marker.
// The configuration port (cfg_we, cfg_idx, cfg_wdata) sets depth, pixel offset
// and trim; write it only while no row is in flight.
// A row accepted on the cursor channel passes the input register, then the
// result register, and is offered on the merged channel from the latter.
// Throughput: one row per cycle while the receiver does not stall; the merge is
// a single combinational pass of bit widening, a barrel shift and the mask/XOR
// between the two registers. When the receiver stalls, the result register holds
// its transaction and the input register keeps accepting until it is full too,
// after which cursor.ready drops; no transaction is lost or repeated.
// Reset (arst_n low) empties both stages and clears all configuration to zero.
`timescale 1ns / 1ps

module cursor_mask_xor_plot_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cmxp_pkg::IDX_W-1:0]  cfg_idx,
	input  logic [cmxp_pkg::CFG_W-1:0]  cfg_wdata,
	cmxp_row_if.sink                    cursor,
	cmxp_res_if.source                  merged
);
	import cmxp_pkg::*;

	cfg_t      cfg_q;
	row_item_t item_in;
	row_item_t item_s1;
	res_item_t res_comb;
	res_item_t res_s2;
	logic      valid_s1;
	logic      valid_s2;
	logic      adv_s1;
	logic      adv_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DEPTH: cfg_q.depth_mode  <= cfg_wdata[DEPTH_W-1:0];
				REG_SHIFT: cfg_q.pixel_shift <= cfg_wdata[SHIFT_W-1:0];
				REG_TRIM:  cfg_q.trim_side   <= cfg_wdata[TRIM_W-1:0];
				default:   ;
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its content moves on
	assign adv_s2       = ~valid_s2 | merged.ready;
	assign adv_s1       = ~valid_s1 | adv_s2;
	assign cursor.ready = adv_s1;

	assign item_in.face_row = cursor.face_row;
	assign item_in.mask_row = cursor.mask_row;
	assign item_in.dest_a   = cursor.dest_a;
	assign item_in.dest_b   = cursor.dest_b;
	assign item_in.last_row = cursor.last_row;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= cursor.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv_s1 && cursor.valid) item_s1 <= item_in;
		if (adv_s2 && valid_s1)     res_s2  <= res_comb;
	end

	cmxp_merge u_merge (
		.cfg  (cfg_q),
		.item (item_s1),
		.res  (res_comb)
	);

	assign merged.valid     = valid_s2;
	assign merged.out_a     = res_s2.out_a;
	assign merged.out_b     = res_s2.out_b;
	assign merged.a_written = res_s2.a_written;
	assign merged.b_written = res_s2.b_written;
	assign merged.last_out  = res_s2.last_out;

endmodule

// ----- tb/cursor_mask_xor_plot_unit_tb.sv -----
// Self-checking testbench for the cursor mask/XOR plot unit: predicted merges vs. merged channel.
`timescale 1ns / 1ps

module cursor_mask_xor_plot_unit_tb;
	import cmxp_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int LONG_HOLD    = 48;
	localparam int RANDOM_ROWS  = 750;

	// Unmapped register index; the block must ignore writes to it
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	// Depth code with no mode of its own, behaves as 4bpp
	localparam logic [DEPTH_W-1:0] DEPTH_SPARE = 2'd3;
	// Trim codes
	localparam logic [TRIM_W-1:0] TRIM_BOTH     = 2'b00;
	localparam logic [TRIM_W-1:0] TRIM_RIGHT    = 2'b01;
	localparam logic [TRIM_W-1:0] TRIM_LEFT_ALT = 2'b10;
	localparam logic [TRIM_W-1:0] TRIM_LEFT     = 2'b11;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	row_item_t row_drv = '0;
	logic row_valid = 1'b0;
	logic res_ready = 1'b0;

	cmxp_row_if cursor_ch();
	cmxp_res_if merged_ch();

	assign cursor_ch.valid    = row_valid;
	assign cursor_ch.face_row = row_drv.face_row;
	assign cursor_ch.mask_row = row_drv.mask_row;
	assign cursor_ch.dest_a   = row_drv.dest_a;
	assign cursor_ch.dest_b   = row_drv.dest_b;
	assign cursor_ch.last_row = row_drv.last_row;
	assign merged_ch.ready    = res_ready;

	cursor_mask_xor_plot_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cursor(cursor_ch),
		.merged(merged_ch)
	);

	// Register shadow, pending rows and expected merges
	cfg_t      plot_cfg = '0;
	row_item_t row_queue[$];
	res_item_t merge_q[$];

	int  err_count = 0;
	int  cycles = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  hold_token = 0;
	int  hold_seen = 0;
	int  rx_pick;
	bit  tx_gappy = 1'b0;
	bit  rx_stalls = 1'b0;
	int  rows_left = 0;
	int  random_sent = 0;
	int  phase_no = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Each pixel bit fills bpp adjacent bits
	function automatic logic [WORD_W-1:0] spread_bits(input logic [ROW_W-1:0] row, input int bpp);
		logic [WORD_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < ROW_W; i++)
			for (int k = 0; k < bpp; k++)
				acc[i*bpp + k] = row[i];
		return acc;
	endfunction

	// Expected merge of one cursor row under the given register values
	function automatic res_item_t merge_row(input row_item_t r, input cfg_t c);
		int bpp, w, s;
		logic [WORD_W-1:0] wmask, face, mask, da, db, ml, fl;
		logic right, left;
		res_item_t e;
		bpp = (c.depth_mode == LG_1BPP) ? 1 : ((c.depth_mode == LG_2BPP) ? 2 : 4);
		w = ROW_W * bpp;
		wmask = (w == WORD_W) ? '1 : ((64'd1 << w) - 64'd1);
		face = spread_bits(r.face_row, bpp);
		mask = spread_bits(r.mask_row, bpp);
		da = r.dest_a & wmask;
		db = r.dest_b & wmask;
		s = c.pixel_shift * bpp;
		right = !c.trim_side[1];
		left = (s != 0) && (c.trim_side[1] || c.trim_side == TRIM_BOTH);
		e = '0;
		if (right) begin
			da = ((da & ~(mask >> s)) ^ (face >> s)) & wmask;
			e.a_written = 1'b1;
		end
		if (left) begin
			ml = (mask << (w - s)) & wmask;
			fl = (face << (w - s)) & wmask;
			if (right) begin
				db = ((db & ~ml) ^ fl) & wmask;
				e.b_written = 1'b1;
			end else begin
				da = ((da & ~ml) ^ fl) & wmask;
				e.a_written = 1'b1;
			end
		end
		e.out_a = da;
		e.out_b = db;
		e.last_out = r.last_row;
		return e;
	endfunction

	// Mostly zero, sometimes short, rarely long
	function automatic int pause_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [ROW_W-1:0] cursor_bits();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return ROW_W'($urandom);
		else if (pick < 62)
			return '0;
		else if (pick < 74)
			return '1;
		else if (pick < 87)
			return 16'h0001 << $urandom_range(0, 15);
		return ~(16'h0001 << $urandom_range(0, 15));
	endfunction

	function automatic logic [WORD_W-1:0] dest_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return {$urandom, $urandom};
		else if (pick < 90)
			return '0;
		return '1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
		err_count++;
	endtask

	// Register write; the shadow follows at the edge that takes it
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEPTH: plot_cfg.depth_mode = data[DEPTH_W-1:0];
			REG_SHIFT: plot_cfg.pixel_shift = data[SHIFT_W-1:0];
			REG_TRIM:  plot_cfg.trim_side = data[TRIM_W-1:0];
			default: ;
		endcase
	endtask

	// All three registers in a randomly rotated order, unused upper data bits random
	task automatic set_regs(input logic [DEPTH_W-1:0] depth, input logic [SHIFT_W-1:0] shift,
			input logic [TRIM_W-1:0] trim);
		int first;
		first = $urandom_range(0, 2);
		for (int k = 0; k < 3; k++) begin
			case ((first + k) % 3)
				0: write_reg(REG_DEPTH, {2'($urandom), depth});
				1: write_reg(REG_SHIFT, shift);
				default: write_reg(REG_TRIM, {2'($urandom), trim});
			endcase
		end
	endtask

	task automatic queue_row(input logic [ROW_W-1:0] face, input logic [ROW_W-1:0] mask,
			input logic [WORD_W-1:0] da, input logic [WORD_W-1:0] db, input logic last);
		row_item_t r;
		r.face_row = face;
		r.mask_row = mask;
		r.dest_a = da;
		r.dest_b = db;
		r.last_row = last;
		row_queue.push_back(r);
	endtask

	// Fixed corner rows: empty, solid, face only, mask only, end pixels, checkerboard
	task automatic queue_edge_rows(input int first, input int count);
		for (int i = first; i < first + count; i++) begin
			case (i % 6)
				0: queue_row(16'h0000, 16'h0000, '0, '0, 1'b0);
				1: queue_row(16'hFFFF, 16'hFFFF, '1, '1, 1'b1);
				2: queue_row(16'hFFFF, 16'h0000, '1, '0, 1'b0);
				3: queue_row(16'h0000, 16'hFFFF, '1, '1, 1'b0);
				4: queue_row(16'h8001, 16'h7FFE, 64'h0123_4567_89AB_CDEF,
					64'hFEDC_BA98_7654_3210, 1'b1);
				default: queue_row(16'hAAAA, 16'h5555, 64'h5A5A_5A5A_5A5A_5A5A,
					64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
			endcase
		end
	endtask

	// Block until every row is sent and merged, then let the pipeline settle
	task automatic wait_idle();
		while (row_queue.size() != 0 || row_valid || merge_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Row sender: next row once the current transaction is taken and any gap elapsed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (row_valid && cursor_ch.ready)
				merge_q.push_back(merge_row(row_drv, plot_cfg));
			if (!row_valid || cursor_ch.ready) begin
				if (gap_left != 0) begin
					row_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (row_queue.size() != 0) begin
					row_drv <= row_queue.pop_front();
					row_valid <= 1'b1;
					gap_left <= tx_gappy ? pause_len() : 0;
				end else begin
					row_valid <= 1'b0;
				end
			end
		end
	end

	// Merge receiver: long hold on request, otherwise random or no stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= LONG_HOLD - 1;
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ready <= 1'b0;
		end else if (rx_stalls) begin
			rx_pick = pause_len();
			if (rx_pick == 0) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b0;
				stall_left <= rx_pick - 1;
			end
		end else begin
			res_ready <= 1'b1;
		end
	end

	// Compare each merged transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && merged_ch.valid && res_ready) begin
			if (merge_q.size() == 0) begin
				flag_mismatch("result with no pending row", merged_ch.out_a, '0);
			end else begin
				res_item_t want;
				want = merge_q.pop_front();
				if (merged_ch.out_a !== want.out_a)
					flag_mismatch("out_a", merged_ch.out_a, want.out_a);
				if (merged_ch.out_b !== want.out_b)
					flag_mismatch("out_b", merged_ch.out_b, want.out_b);
				if (merged_ch.a_written !== want.a_written)
					flag_mismatch("a_written", WORD_W'(merged_ch.a_written),
						WORD_W'(want.a_written));
				if (merged_ch.b_written !== want.b_written)
					flag_mismatch("b_written", WORD_W'(merged_ch.b_written),
						WORD_W'(want.b_written));
				if (merged_ch.last_out !== want.last_out)
					flag_mismatch("last_out", WORD_W'(merged_ch.last_out),
						WORD_W'(want.last_out));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d merges outstanding", cycles, merge_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus: directed corners, then random register settings with random rows
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: 1bpp, no offset, both parts
		queue_edge_rows(0, 4);
		wait_idle();
		set_regs(LG_2BPP, 4'd1, TRIM_BOTH);
		queue_edge_rows(1, 3);
		wait_idle();
		set_regs(LG_4BPP, 4'd15, TRIM_BOTH);
		queue_edge_rows(3, 3);
		wait_idle();
		set_regs(DEPTH_SPARE, 4'd7, TRIM_RIGHT);
		queue_edge_rows(4, 2);
		wait_idle();
		set_regs(LG_1BPP, 4'd15, TRIM_LEFT);
		queue_edge_rows(1, 2);
		wait_idle();
		// Left only with no offset: nothing gets merged
		set_regs(LG_4BPP, 4'd0, TRIM_LEFT);
		queue_edge_rows(1, 2);
		wait_idle();
		set_regs(LG_2BPP, 4'd8, TRIM_LEFT_ALT);
		queue_edge_rows(4, 2);
		wait_idle();
		write_reg(REG_SPARE, 4'hF);
		queue_edge_rows(2, 2);
		wait_idle();

		while (random_sent < RANDOM_ROWS) begin
			int n;
			int pick;
			logic [SHIFT_W-1:0] shift;
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				write_reg(IDX_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 15)));
			end else begin
				pick = $urandom_range(0, 99);
				shift = (pick < 20) ? 4'd0 : ((pick < 40) ? 4'd15 : SHIFT_W'($urandom));
				set_regs(DEPTH_W'($urandom), shift, TRIM_W'($urandom));
			end
			n = $urandom_range(10, 50);
			tx_gappy = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			// Back-to-back rows against a held-off receiver fill the pipeline
			if (phase_no % 6 == 0)
				tx_gappy = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (rows_left == 0)
					rows_left = $urandom_range(1, 16);
				queue_row(cursor_bits(), cursor_bits(), dest_word(), dest_word(), rows_left == 1);
				rows_left--;
			end
			if (phase_no % 6 == 0)
				hold_token++;
			random_sent += n;
			phase_no++;
			wait_idle();
		end

		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
